/* hdl/psk2rfd_pkg.sv */
package psk2rfd_pkg;

  localparam int DUR_W     = 20;
  localparam int PER_W     = 12;
  localparam int NUM_W     = DUR_W + 1;
  localparam int WORD_W    = 56;
  localparam int NUM_WORDS = 4;
  localparam int IDX_W     = 2;

  localparam logic [PER_W-1:0] PER_RESET = 12'd255;
  localparam logic [IDX_W-1:0] LAST_WORD = 2'd3;
  localparam logic [IDX_W-1:0] FIRST_WORD = 2'd0;

  localparam int FRAME_BITS_DEF    = 224;
  localparam int PREAMBLE_BITS_DEF = 30;
  localparam int HISTORY_BYTES_DEF = 56;

  typedef struct packed {
    logic             capture;
    logic             div_start;
    logic             load_cnt;
    logic             shift;
    logic             sel_inv;
    logic             decode;
    logic             out_load;
    logic             out_found;
    logic [IDX_W-1:0] out_idx;
    logic             out_last;
  } ctrl_cmd_t;

  typedef struct packed {
    logic eob;
    logic above_half;
    logic div_done;
    logic q_big;
    logic cnt_zero;
    logic hit;
    logic out_free;
  } dp_sts_t;

endpackage

/* hdl/psk2rfd_if.sv */
interface psk2rfd_evt_if;
  import psk2rfd_pkg::*;
  logic             valid;
  logic             ready;
  logic             level;
  logic [DUR_W-1:0] duration_us;
  logic             end_of_batch;
  modport source (output valid, level, duration_us, end_of_batch, input ready);
  modport sink (input valid, level, duration_us, end_of_batch, output ready);
endinterface

interface psk2rfd_res_if;
  import psk2rfd_pkg::*;
  logic              valid;
  logic              ready;
  logic              found;
  logic [IDX_W-1:0]  word_index;
  logic [WORD_W-1:0] id_word;
  logic              last;
  logic              batch_done;
  modport source (output valid, found, word_index, id_word, last, batch_done, input ready);
  modport sink (input valid, found, word_index, id_word, last, batch_done, output ready);
endinterface

interface psk2rfd_cfg_if;
  import psk2rfd_pkg::*;
  logic             valid;
  logic             ready;
  logic [PER_W-1:0] bit_period_us;
  modport source (output valid, bit_period_us, input ready);
  modport sink (input valid, bit_period_us, output ready);
endinterface

/* hdl/psk2rfd_div.sv */
module psk2rfd_div (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           start,
  input  logic [psk2rfd_pkg::NUM_W-1:0]  num,
  input  logic [psk2rfd_pkg::PER_W-1:0]  den,
  output logic [psk2rfd_pkg::NUM_W-1:0]  quotient,
  output logic                           done
);
  import psk2rfd_pkg::*;

  localparam int CNT_W = $clog2(NUM_W + 1);

  logic             busy;
  logic [CNT_W-1:0] cnt;
  logic [PER_W-1:0] rem;
  logic [PER_W-1:0] den_r;
  logic [PER_W:0]   rem_sh;
  logic [PER_W:0]   diff;
  logic             ge;

  // restoring division, one quotient bit per cycle, dividend shifts out of quotient
  assign rem_sh = {rem, quotient[NUM_W-1]};
  assign ge     = rem_sh >= {1'b0, den_r};
  assign diff   = rem_sh - {1'b0, den_r};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy     <= 1'b1;
        cnt      <= '0;
        rem      <= '0;
        den_r    <= den;
        quotient <= num;
      end else if (busy) begin
        rem      <= ge ? diff[PER_W-1:0] : rem_sh[PER_W-1:0];
        quotient <= {quotient[NUM_W-2:0], ge};
        cnt      <= cnt + 1'b1;
        if (cnt == CNT_W'(NUM_W - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

endmodule

/* hdl/psk2rfd_dp.sv */
module psk2rfd_dp #(
  parameter int FRAME_BITS    = psk2rfd_pkg::FRAME_BITS_DEF,
  parameter int PREAMBLE_BITS = psk2rfd_pkg::PREAMBLE_BITS_DEF,
  parameter int HISTORY_BYTES = psk2rfd_pkg::HISTORY_BYTES_DEF
) (
  input  logic                            clk,
  input  logic                            rst,
  input  psk2rfd_pkg::ctrl_cmd_t          cmd,
  output psk2rfd_pkg::dp_sts_t            sts,
  input  logic                            in_level,
  input  logic [psk2rfd_pkg::DUR_W-1:0]   in_duration_us,
  input  logic                            in_end_of_batch,
  input  logic                            cfg_we,
  input  logic [psk2rfd_pkg::PER_W-1:0]   cfg_data,
  output logic                            out_valid,
  input  logic                            out_ready,
  output logic                            out_found,
  output logic [psk2rfd_pkg::IDX_W-1:0]   out_word_index,
  output logic [psk2rfd_pkg::WORD_W-1:0]  out_id_word,
  output logic                            out_last,
  output logic                            out_batch_done
);
  import psk2rfd_pkg::*;

  localparam int HIST_BITS = HISTORY_BYTES * 8;
  localparam int CNT_W     = $clog2(FRAME_BITS);
  localparam logic [NUM_W-1:0] FRAME_Q = NUM_W'(FRAME_BITS);

  logic                 lvl;
  logic [DUR_W-1:0]     dur;
  logic                 eob;
  logic [PER_W-1:0]     period;
  logic [PER_W-1:0]     per_eff;
  logic [PER_W-2:0]     half;
  logic [HIST_BITS-1:0] true_hist;
  logic [HIST_BITS-1:0] inv_hist;
  logic [HIST_BITS-1:0] sel_hist;
  logic [HIST_BITS-1:0] shifted;
  logic                 feed_bit;
  logic [CNT_W-1:0]     cnt;
  logic [WORD_W-1:0]    words     [NUM_WORDS];
  logic [WORD_W-1:0]    dec_words [NUM_WORDS];
  logic [NUM_W-1:0]     quotient;
  logic [NUM_W-1:0]     numer;
  logic                 div_done;

  function automatic logic hb(input logic [HIST_BITS-1:0] h, input int idx);
    return (idx < HIST_BITS) ? h[idx] : 1'b0;
  endfunction

  function automatic logic pre_at(input logic [HIST_BITS-1:0] h, input int off,
                                  input logic first);
    logic ok;
    ok = 1'b1;
    for (int i = 0; i < PREAMBLE_BITS; i++) begin
      if (i == 0) ok &= (hb(h, off) == first);
      else        ok &= (hb(h, off + i) != first);
    end
    return ok;
  endfunction

  function automatic logic frame_ready(input logic [HIST_BITS-1:0] h);
    return pre_at(h, 0, 1'b1) &&
           (pre_at(h, FRAME_BITS, 1'b1) || pre_at(h, FRAME_BITS, 1'b0));
  endfunction

  assign per_eff  = (period == '0) ? PER_W'(1) : period;
  assign half     = per_eff[PER_W-1:1];
  assign numer    = {1'b0, dur} + NUM_W'(half);
  assign sel_hist = cmd.sel_inv ? inv_hist : true_hist;
  assign feed_bit = cmd.sel_inv ? ~lvl : lvl;
  // index 0 is the oldest bit; new bit enters at the top
  assign shifted  = {feed_bit, sel_hist[HIST_BITS-1:1]};

  always_comb begin
    logic b;
    for (int k = 0; k < NUM_WORDS; k++) begin
      for (int j = 0; j < WORD_W; j++) begin
        b = 1'b0;
        if (k * WORD_W + j < FRAME_BITS)
          b = hb(sel_hist, k * WORD_W + j) ^ hb(sel_hist, k * WORD_W + j + 1);
        dec_words[k][WORD_W-1-j] = b;
      end
    end
  end

  psk2rfd_div u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (cmd.div_start),
    .num      (numer),
    .den      (per_eff),
    .quotient (quotient),
    .done     (div_done)
  );

  assign sts.eob        = eob;
  assign sts.above_half = dur > DUR_W'(half);
  assign sts.div_done   = div_done;
  assign sts.q_big      = quotient >= FRAME_Q;
  assign sts.cnt_zero   = (cnt == '0);
  assign sts.hit        = frame_ready(shifted);
  assign sts.out_free   = !out_valid || out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      period    <= PER_RESET;
      true_hist <= '0;
      inv_hist  <= '0;
      out_valid <= 1'b0;
    end else begin
      if (cfg_we) period <= cfg_data;
      if (cmd.shift) begin
        if (cmd.sel_inv) inv_hist <= shifted;
        else             true_hist <= shifted;
      end
      if (cmd.out_load)  out_valid <= 1'b1;
      else if (out_ready) out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      lvl <= in_level;
      dur <= in_duration_us;
      eob <= in_end_of_batch;
    end
    if (cmd.load_cnt)   cnt <= quotient[CNT_W-1:0];
    else if (cmd.shift) cnt <= cnt - 1'b1;
    if (cmd.decode) words <= dec_words;
    if (cmd.out_load) begin
      out_found      <= cmd.out_found;
      out_word_index <= cmd.out_idx;
      out_id_word    <= cmd.out_found ? words[cmd.out_idx] : '0;
      out_last       <= cmd.out_last;
      out_batch_done <= eob;
    end
  end

endmodule

/* hdl/psk2rfd_ctrl.sv */
module psk2rfd_ctrl (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   in_valid,
  output logic                   in_ready,
  input  psk2rfd_pkg::dp_sts_t   sts,
  output psk2rfd_pkg::ctrl_cmd_t cmd
);
  import psk2rfd_pkg::*;

  typedef enum logic [2:0] {IDLE, CHECK, DIV, FEED, DECODE, EMIT} state_t;

  state_t           state;
  logic             skipping;
  logic             hit;
  logic             sel_inv;
  logic [IDX_W-1:0] idx;

  assign in_ready = (state == IDLE);

  always_comb begin
    cmd           = '0;
    cmd.sel_inv   = sel_inv;
    cmd.out_idx   = idx;
    cmd.out_found = hit;
    cmd.out_last  = !hit || (idx == LAST_WORD);
    unique case (state)
      IDLE:   cmd.capture   = in_valid;
      CHECK:  cmd.div_start = !skipping && sts.above_half;
      DIV:    cmd.load_cnt  = sts.div_done && !sts.q_big;
      FEED: begin
        cmd.shift    = !sts.cnt_zero;
        cmd.load_cnt = sts.cnt_zero && !sel_inv;
      end
      DECODE: cmd.decode   = 1'b1;
      EMIT:   cmd.out_load = sts.out_free;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= IDLE;
      skipping <= 1'b0;
      hit      <= 1'b0;
      sel_inv  <= 1'b0;
      idx      <= FIRST_WORD;
    end else begin
      unique case (state)
        IDLE: if (in_valid) state <= CHECK;
        CHECK: begin
          hit     <= 1'b0;
          idx     <= FIRST_WORD;
          sel_inv <= 1'b0;
          if (skipping) begin
            if (sts.eob) skipping <= 1'b0;
            state <= EMIT;
          end else if (sts.above_half) begin
            state <= DIV;
          end else begin
            state <= EMIT;
          end
        end
        DIV: if (sts.div_done) state <= sts.q_big ? EMIT : FEED;
        FEED: begin
          if (sts.cnt_zero) begin
            // count exhausted: rerun with the inverted level after the true history, else emit
            if (!sel_inv) sel_inv <= 1'b1;
            else          state   <= EMIT;
          end else if (sts.hit) begin
            hit      <= 1'b1;
            skipping <= !sts.eob;
            state    <= DECODE;
          end
        end
        DECODE: state <= EMIT;
        EMIT: begin
          if (sts.out_free) begin
            if (!hit || idx == LAST_WORD) state <= IDLE;
            else                          idx   <= idx + 1'b1;
          end
        end
        default: state <= IDLE;
      endcase
    end
  end

  a_done_in_div: assert property (@(posedge clk) disable iff (rst)
    sts.div_done |-> state == DIV)
    else $error("divider finished outside DIV");

  a_no_shift_empty: assert property (@(posedge clk) disable iff (rst)
    cmd.shift |-> !sts.cnt_zero)
    else $error("shift with zero count");

  a_hit_decodes: assert property (@(posedge clk) disable iff (rst)
    cmd.shift && sts.hit |=> state == DECODE && hit)
    else $error("hit not followed by decode");

  a_skip_no_shift: assert property (@(posedge clk) disable iff (rst)
    skipping |-> !cmd.shift)
    else $error("history fed while skipping");

  a_last_to_idle: assert property (@(posedge clk) disable iff (rst)
    cmd.out_load && cmd.out_last |=> state == IDLE)
    else $error("controller busy after final result");

endmodule

/* hdl/psk2_rfid_frame_decoder_unit.sv */
// PSK2 frame decoder for 224-bit long-format proximity tags.
// events : one demodulated phase event per request (level, duration in us,
//          end_of_batch). Taken only while the unit is idle.
// results: one request with found=0 and last=1 per event that decodes nothing,
//          or four requests (found=1, word_index 0..3, last on the fourth)
//          when the event completes a frame. batch_done echoes end_of_batch.
// cfg    : bit period in us; always ready, write only while idle. 0 acts as 1.
// Steps per event: a check, the bit-serial divider, then history shifts over the
// true and then the inverted history, a decode step and one emit per result.
// The final result sits in an output register; the next event is taken while
// it waits. A stalled receiver holds the unit in its emit state.
// Reset clears both histories, the skip flag and the period (to 255) at once.
module psk2_rfid_frame_decoder_unit #(
  parameter int FRAME_BITS    = psk2rfd_pkg::FRAME_BITS_DEF,
  parameter int PREAMBLE_BITS = psk2rfd_pkg::PREAMBLE_BITS_DEF,
  parameter int HISTORY_BYTES = psk2rfd_pkg::HISTORY_BYTES_DEF
) (
  input logic           clk,
  input logic           rst,
  psk2rfd_evt_if.sink   events,
  psk2rfd_res_if.source results,
  psk2rfd_cfg_if.sink   cfg
);
  import psk2rfd_pkg::*;

  ctrl_cmd_t cmd;
  dp_sts_t   sts;
  logic      in_ready;

  assign events.ready = in_ready;
  assign cfg.ready    = 1'b1;

  psk2rfd_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (events.valid),
    .in_ready (in_ready),
    .sts      (sts),
    .cmd      (cmd)
  );

  psk2rfd_dp #(
    .FRAME_BITS    (FRAME_BITS),
    .PREAMBLE_BITS (PREAMBLE_BITS),
    .HISTORY_BYTES (HISTORY_BYTES)
  ) u_dp (
    .clk             (clk),
    .rst             (rst),
    .cmd             (cmd),
    .sts             (sts),
    .in_level        (events.level),
    .in_duration_us  (events.duration_us),
    .in_end_of_batch (events.end_of_batch),
    .cfg_we          (cfg.valid),
    .cfg_data        (cfg.bit_period_us),
    .out_valid       (results.valid),
    .out_ready       (results.ready),
    .out_found       (results.found),
    .out_word_index  (results.word_index),
    .out_id_word     (results.id_word),
    .out_last        (results.last),
    .out_batch_done  (results.batch_done)
  );

endmodule
